/* rtl/stuffed_frame_receiver_unit_defines.svh */
// Assertion macros for the stuffed frame receiver.
`ifndef STUFFED_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define STUFFED_FRAME_RECEIVER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, held off during reset.
`define SFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfr assertion failed");
// Next-cycle implication, held off during reset.
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfr assertion failed");
`else
`define SFR_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/sfr_pkg.sv */
// Shared types and constants of the stuffed frame receiver.
package sfr_pkg;

  localparam int unsigned FRAME_LENGTH = 16;
  localparam int unsigned POS_W        = 6;

  localparam logic [POS_W-1:0] POS_MAX   = {POS_W{1'b1}};
  localparam logic [POS_W-1:0] SUM_LAST  = POS_W'(FRAME_LENGTH - 3);
  localparam logic [POS_W-1:0] CHECK_POS = POS_W'(FRAME_LENGTH - 2);
  localparam logic [POS_W-1:0] STOP_POS  = POS_W'(FRAME_LENGTH - 1);

  localparam logic [7:0] ESCAPE_XOR = 8'h20;

  localparam logic [7:0] START_RESET  = 8'd126;
  localparam logic [7:0] STOP_RESET   = 8'd127;
  localparam logic [7:0] ESCAPE_RESET = 8'd125;

  typedef enum logic [1:0] {
    REG_START  = 2'd0,
    REG_STOP   = 2'd1,
    REG_ESCAPE = 2'd2
  } sfr_reg_t;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_END  = 1'b1
  } sfr_kind_t;

  typedef enum logic [1:0] {
    STATUS_GOOD       = 2'd0,
    STATUS_BAD_SUM    = 2'd1,
    STATUS_BAD_LENGTH = 2'd2
  } sfr_status_t;

endpackage

/* rtl/sfr_in_if.sv */
// Raw byte channel into the stuffed frame receiver.
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

/* rtl/sfr_out_if.sv */
// Result channel out of the stuffed frame receiver.
interface sfr_out_if;
  logic                valid;
  logic                ready;
  sfr_pkg::sfr_kind_t  item_kind;
  logic [7:0]          frame_byte;
  logic [5:0]          byte_position;
  sfr_pkg::sfr_status_t frame_status;

  modport source (output valid, output item_kind, output frame_byte,
                  output byte_position, output frame_status, input ready);
  modport sink (input valid, input item_kind, input frame_byte,
                input byte_position, input frame_status, output ready);
endinterface

/* rtl/stuffed_frame_receiver_unit.sv */
// Top level of the stuffed frame receiver: deframing, checksum and APB registers.
// Registered output: a result item appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the single output register refills in the cycle
// it is drained, so the only limit is the sink's ready.
// Reset: synchronous, active low; hunting for start, codes back to 126/127/125.
`include "stuffed_frame_receiver_unit_defines.svh"
module stuffed_frame_receiver_unit (
  input  logic        clk,
  input  logic        rst_n,
  sfr_in_if.sink      in_ch,
  sfr_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import sfr_pkg::*;

  // Configuration registers
  logic [7:0] start_code_r, stop_code_r, escape_code_r;
  logic       cfg_wr;
  sfr_reg_t   cfg_idx;

  // Frame state
  logic             in_frame_r, in_frame_nxt;
  logic             esc_pend_r, esc_pend_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       check_r, check_nxt;
  logic             ovf_r, ovf_nxt;

  // Output register
  logic             out_valid_r, out_valid_nxt;
  sfr_kind_t        kind_r, kind_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic [POS_W-1:0] opos_r, opos_nxt;
  sfr_status_t      status_r, status_nxt;

  logic       accept;
  logic [7:0] b;
  logic       emit_data;
  logic [7:0] data_val;
  logic       is_stop, is_esc, is_start;

  // ---------------------------------------------------------------------------
  // APB port: pready tied high, write lands on the access phase.
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = sfr_reg_t'(cfg_paddr[3:2]);

  always_comb begin
    case (cfg_idx)
      REG_START:  cfg_prdata = {24'd0, start_code_r};
      REG_STOP:   cfg_prdata = {24'd0, stop_code_r};
      REG_ESCAPE: cfg_prdata = {24'd0, escape_code_r};
      default:    cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_code_r  <= START_RESET;
      stop_code_r   <= STOP_RESET;
      escape_code_r <= ESCAPE_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_START:  start_code_r  <= cfg_pwdata[7:0];
        REG_STOP:   stop_code_r   <= cfg_pwdata[7:0];
        REG_ESCAPE: escape_code_r <= cfg_pwdata[7:0];
        default:    ; // index 3: no register, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: take a byte whenever the output slot is free or draining now.
  // ---------------------------------------------------------------------------
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;

  // Stop is tested before escape, escape before start.
  assign is_stop  = (b == stop_code_r);
  assign is_esc   = (b == escape_code_r);
  assign is_start = (b == start_code_r);

  always_comb begin
    in_frame_nxt  = in_frame_r;
    esc_pend_nxt  = esc_pend_r;
    pos_nxt       = pos_r;
    sum_nxt       = sum_r;
    check_nxt     = check_r;
    ovf_nxt       = ovf_r;
    emit_data     = 1'b0;
    data_val      = b;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    kind_nxt      = kind_r;
    byte_nxt      = byte_r;
    opos_nxt      = opos_r;
    status_nxt    = status_r;

    if (accept) begin
      out_valid_nxt = 1'b0;
      if (!in_frame_r) begin
        // Hunting: only the start code opens a frame, as position 0.
        if (is_start) begin
          in_frame_nxt = 1'b1;
          esc_pend_nxt = 1'b0;
          pos_nxt      = '0;
          sum_nxt      = 8'd0;
          check_nxt    = 8'd0;
          ovf_nxt      = 1'b0;
          emit_data    = 1'b1;
        end
      end else if (is_stop) begin
        // A raw stop always closes, even with an escape dangling.
        in_frame_nxt  = 1'b0;
        esc_pend_nxt  = 1'b0;
        out_valid_nxt = 1'b1;
        kind_nxt      = KIND_END;
        byte_nxt      = 8'd0;
        opos_nxt      = pos_r;
        if (ovf_r || esc_pend_r || pos_r != STOP_POS) begin
          status_nxt = STATUS_BAD_LENGTH;
        end else if (~sum_r == check_r) begin
          status_nxt = STATUS_GOOD;
        end else begin
          status_nxt = STATUS_BAD_SUM;
        end
      end else if (esc_pend_r) begin
        esc_pend_nxt = 1'b0;
        data_val     = b ^ ESCAPE_XOR;
        emit_data    = 1'b1;
      end else if (is_esc) begin
        esc_pend_nxt = 1'b1;
      end else if (is_start && pos_r == POS_W'(1)) begin
        // repeated start straight after the opening one: dropped
      end else begin
        emit_data = 1'b1;
      end

      if (emit_data) begin
        // Uses pos_nxt so the opening byte sees position 0 and a fresh sum.
        if (pos_nxt >= POS_W'(1) && pos_nxt <= SUM_LAST) begin
          sum_nxt = sum_nxt + data_val;
        end
        if (pos_nxt == CHECK_POS) begin
          check_nxt = data_val;
        end
        out_valid_nxt = 1'b1;
        kind_nxt      = KIND_DATA;
        byte_nxt      = data_val;
        opos_nxt      = pos_nxt;
        status_nxt    = STATUS_GOOD;
        if (pos_nxt == POS_MAX) begin
          ovf_nxt = 1'b1;
        end else begin
          pos_nxt = pos_nxt + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r  <= 1'b0;
      esc_pend_r  <= 1'b0;
      pos_r       <= '0;
      sum_r       <= 8'd0;
      check_r     <= 8'd0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_frame_r  <= in_frame_nxt;
      esc_pend_r  <= esc_pend_nxt;
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
      check_r     <= check_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload of the result item: no reset needed.
  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    byte_r   <= byte_nxt;
    opos_r   <= opos_nxt;
    status_r <= status_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.item_kind     = kind_r;
  assign out_ch.frame_byte    = byte_r;
  assign out_ch.byte_position = opos_r;
  assign out_ch.frame_status  = status_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `SFR_ASSERT_NEXT(a_start_opens, clk, rst_n, accept && !in_frame_r && is_start, out_valid_r && kind_r == KIND_DATA && opos_r == '0 && in_frame_r)
  `SFR_ASSERT_NEXT(a_stop_closes, clk, rst_n, accept && in_frame_r && is_stop, !in_frame_r && out_valid_r && kind_r == KIND_END)
  `SFR_ASSERT_NOW(a_esc_in_frame, clk, rst_n, esc_pend_r, in_frame_r)
  `SFR_ASSERT_NOW(a_ovf_saturated, clk, rst_n, ovf_r, pos_r == POS_MAX)

endmodule
